>>> design/bcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Brake caliper sequencer package
// Shared types, register codes and reset values for the sequencer.
// ----------------------------------------------------------------------------
package bcs_pkg;

  localparam int HallW  = 12;
  localparam int TicksW = 5;
  localparam int CfgIdxW = 3;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_CONTROL_MODE   = 3'd0,
    CFG_CALIPER_SELECT = 3'd1,
    CFG_HALL_THRESHOLD = 3'd2,
    CFG_RELEASE_SINGLE = 3'd3,
    CFG_APPLY_SINGLE   = 3'd4,
    CFG_RELEASE_BOTH   = 3'd5,
    CFG_APPLY_BOTH     = 3'd6
  } cfg_index_e;

  // Caliper selection codes for per-side mode
  localparam logic [1:0] SEL_NONE  = 2'd0;
  localparam logic [1:0] SEL_RIGHT = 2'd1;
  localparam logic [1:0] SEL_LEFT  = 2'd2;
  localparam logic [1:0] SEL_BOTH  = 2'd3;

  // Reset values of the registers
  localparam logic [HallW-1:0]  HallThresholdReset  = 12'd1240;
  localparam logic [TicksW-1:0] ReleaseSingleReset  = 5'd14;
  localparam logic [TicksW-1:0] ApplySingleReset    = 5'd15;
  localparam logic [TicksW-1:0] ReleaseBothReset    = 5'd30;
  localparam logic [TicksW-1:0] ApplyBothReset      = 5'd22;

  typedef struct packed {
    logic              control_mode;
    logic [1:0]        caliper_select;
    logic [HallW-1:0]  hall_threshold;
    logic [TicksW-1:0] release_ticks_single;
    logic [TicksW-1:0] apply_ticks_single;
    logic [TicksW-1:0] release_ticks_both;
    logic [TicksW-1:0] apply_ticks_both;
  } cfg_t;

  typedef struct packed {
    logic             lock_request;
    logic [HallW-1:0] hall_right;
    logic [HallW-1:0] hall_left;
  } item_t;

  typedef struct packed {
    logic right_enable;
    logic left_enable;
    logic drive_forward;
    logic drive_reverse;
    logic brake_status;
    logic red_led;
    logic green_led;
  } result_t;

endpackage

>>> design/bcs_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Brake caliper sequencer configuration registers
// Holds the mode, selection, threshold and tick counts written over the
// configuration channel.
// ----------------------------------------------------------------------------
module bcs_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bcs_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [bcs_pkg::HallW-1:0]     cfg_data,
  output bcs_pkg::cfg_t                 cfg
);
  import bcs_pkg::*;

  // Always take writes
  assign cfg_ready = 1'b1;

  // Write the addressed register; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.control_mode         <= 1'b0;
      cfg.caliper_select       <= SEL_NONE;
      cfg.hall_threshold       <= HallThresholdReset;
      cfg.release_ticks_single <= ReleaseSingleReset;
      cfg.apply_ticks_single   <= ApplySingleReset;
      cfg.release_ticks_both   <= ReleaseBothReset;
      cfg.apply_ticks_both     <= ApplyBothReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_e'(cfg_index))
        CFG_CONTROL_MODE:   cfg.control_mode         <= cfg_data[0];
        CFG_CALIPER_SELECT: cfg.caliper_select       <= cfg_data[1:0];
        CFG_HALL_THRESHOLD: cfg.hall_threshold       <= cfg_data;
        CFG_RELEASE_SINGLE: cfg.release_ticks_single <= cfg_data[TicksW-1:0];
        CFG_APPLY_SINGLE:   cfg.apply_ticks_single   <= cfg_data[TicksW-1:0];
        CFG_RELEASE_BOTH:   cfg.release_ticks_both   <= cfg_data[TicksW-1:0];
        CFG_APPLY_BOTH:     cfg.apply_ticks_both     <= cfg_data[TicksW-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> design/bcs_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Brake caliper sequencer core
// Per-tick step logic: side selection, hall gating, tick counting and
// completion, with lock marks, counts, pin states and the result register.
// ----------------------------------------------------------------------------
module bcs_core (
  input  logic             clk,
  input  logic             rst,
  input  bcs_pkg::cfg_t    cfg,
  input  logic             item_valid,
  input  bcs_pkg::item_t   item,
  output logic             item_take,
  output logic             result_valid,
  input  logic             result_stall,
  output bcs_pkg::result_t result
);
  import bcs_pkg::*;

  logic              right_locked, left_locked;
  logic [TicksW-1:0] right_ticks, left_ticks;
  result_t           pins;

  logic              right_locked_next, left_locked_next;
  logic [TicksW-1:0] right_ticks_next, left_ticks_next;
  result_t           pins_next;

  logic              out_free;
  logic              side_active, side_left, both;
  logic              side_locked, go, done;
  logic [TicksW-1:0] side_ticks, ticks_inc, target;
  logic [HallW-1:0]  side_hall;

  // Take a request when the result register is free or being drained
  assign out_free  = !result_valid || !result_stall;
  assign item_take = item_valid && out_free;

  // Pick the sequenced side and set the enables
  always_comb begin
    pins_next   = pins;
    side_active = 1'b0;
    side_left   = 1'b0;
    both        = cfg.control_mode;
    if (cfg.control_mode) begin
      pins_next.right_enable = 1'b1;
      pins_next.left_enable  = 1'b1;
      side_active            = 1'b1;
    end else begin
      case (cfg.caliper_select)
        SEL_RIGHT: begin
          pins_next.right_enable = 1'b1;
          pins_next.left_enable  = 1'b0;
          side_active            = 1'b1;
        end
        SEL_LEFT: begin
          pins_next.right_enable = 1'b0;
          pins_next.left_enable  = 1'b1;
          side_active            = 1'b1;
          side_left              = 1'b1;
        end
        SEL_BOTH: begin
          pins_next.right_enable = 1'b1;
          pins_next.left_enable  = 1'b1;
          side_active            = 1'b1;
        end
        default: begin
          pins_next.right_enable = 1'b0;
          pins_next.left_enable  = 1'b0;
        end
      endcase
    end

    side_locked = side_left ? left_locked : right_locked;
    side_ticks  = side_left ? left_ticks : right_ticks;
    side_hall   = side_left ? item.hall_left : item.hall_right;

    // Move only while the mark disagrees and the hall reading is high enough
    go = side_active && (side_locked != item.lock_request) &&
         (side_hall >= cfg.hall_threshold);

    if (item.lock_request)
      target = both ? cfg.apply_ticks_both : cfg.apply_ticks_single;
    else
      target = both ? cfg.release_ticks_both : cfg.release_ticks_single;

    ticks_inc = side_ticks + TicksW'(1);
    done      = go && (ticks_inc == target);

    right_locked_next = right_locked;
    left_locked_next  = left_locked;
    right_ticks_next  = right_ticks;
    left_ticks_next   = left_ticks;

    if (go) begin
      pins_next.drive_forward = !item.lock_request;
      pins_next.drive_reverse = item.lock_request;
      if (side_left)
        left_ticks_next = done ? '0 : ticks_inc;
      else
        right_ticks_next = done ? '0 : ticks_inc;
    end

    // Finish the motion: drop drive and enables, flip the mark, update status and LEDs
    if (done) begin
      pins_next.drive_forward = 1'b0;
      pins_next.drive_reverse = 1'b0;
      pins_next.right_enable  = 1'b0;
      pins_next.left_enable   = 1'b0;
      pins_next.brake_status  = item.lock_request;
      pins_next.red_led       = both || item.lock_request;
      pins_next.green_led     = both || !item.lock_request;
      if (side_left)
        left_locked_next = item.lock_request;
      else
        right_locked_next = item.lock_request;
    end
  end

  // Advance the sequencer state on each taken request
  always_ff @(posedge clk) begin
    if (rst) begin
      right_locked <= 1'b0;
      left_locked  <= 1'b0;
      right_ticks  <= '0;
      left_ticks   <= '0;
      pins         <= '0;
    end else if (item_take) begin
      right_locked <= right_locked_next;
      left_locked  <= left_locked_next;
      right_ticks  <= right_ticks_next;
      left_ticks   <= left_ticks_next;
      pins         <= pins_next;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (item_take) begin
      result_valid <= 1'b1;
    end else if (out_free) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take)
      result <= pins_next;
  end

  // Never drive both directions at once
  assert property (@(posedge clk) disable iff (rst)
    !(pins.drive_forward && pins.drive_reverse))
    else $error("forward and reverse drive both active");

  // A result always reports the pin state it left behind
  assert property (@(posedge clk) disable iff (rst)
    item_take |=> (result == pins))
    else $error("result differs from pin state");

  // Completion turns every enable and direction off
  assert property (@(posedge clk) disable iff (rst)
    (item_take && done) |=> (!pins.right_enable && !pins.left_enable &&
                             !pins.drive_forward && !pins.drive_reverse))
    else $error("drive left on after completion");

  // Idle ticks keep the counts and the marks
  assert property (@(posedge clk) disable iff (rst)
    (item_take && !go) |=> ($stable(right_ticks) && $stable(left_ticks) &&
                            $stable(right_locked) && $stable(left_locked)))
    else $error("sequencer state changed on an idle tick");

endmodule

>>> design/brake_caliper_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Brake caliper sequencer
// Drives caliper enables and motor direction from lock requests and hall
// readings, counting ticks of motion until a lock or release completes.
// ----------------------------------------------------------------------------
// Usage:
//   item_* carries one 100 ms tick (lock request, right and left hall
//   samples); a request is taken when item_valid is high and item_stall low.
//   result_* returns the seven pin states after that tick, one result per
//   request, taken when result_valid is high and result_stall low.
//   cfg_* writes one register per handshake; cfg_ready is always high.
//   Write configuration only while no request is in flight.
// Path: a taken request loads the input register; the step logic then
//   fills the result register from it once the result register is free.
// Throughput: one request per cycle while the result is not stalled;
//   the combinational step logic between the input register and the
//   state registers sets that rate.
// Reset: rst clears lock marks, tick counts and pins, and loads the default
//   register values. The block is ready the cycle after reset.
// Stall: a stalled result holds; the input register still takes one more
//   request, then item_stall rises until the result drains.
// ----------------------------------------------------------------------------
module brake_caliper_sequencer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  bcs_pkg::item_t              item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output bcs_pkg::result_t            result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bcs_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [bcs_pkg::HallW-1:0]   cfg_data
);
  import bcs_pkg::*;

  cfg_t  cfg;
  logic  held_valid;
  item_t held;
  logic  held_take;

  // Stall only while a held request cannot move on
  assign item_stall = held_valid && !held_take;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      held_valid <= 1'b1;
    end else if (held_take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall)
      held <= item;
  end

  bcs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bcs_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (held_valid),
    .item         (held),
    .item_take    (held_take),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

>>> tb/brake_caliper_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Brake caliper sequencer testbench
// Sends hall/lock requests through the sequencer with random gaps and result
// stalls, tracks lock marks, tick counts and pin states in a local predictor,
// and compares every result pin by pin. Directed checks of each caliper
// selection and mode come first, then random request runs over many settings.
// ----------------------------------------------------------------------------
module brake_caliper_sequencer_tb;
  import bcs_pkg::*;

  localparam bit SideRight = 1'b0;
  localparam bit SideLeft  = 1'b1;

  logic                clk;
  logic                rst;
  logic                item_valid;
  logic                item_stall;
  item_t               item;
  logic                result_valid;
  logic                result_stall;
  result_t             result;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [HallW-1:0]    cfg_data;

  // Predictor state: register copy, lock marks, tick counts, pins
  cfg_t                cfg_shadow;
  logic                side_locked [2];
  logic [TicksW-1:0]   side_ticks [2];
  result_t             pins;
  result_t             pin_expect_q [$];
  result_t             pin_want;

  int unsigned         error_count;
  int unsigned         burst_left;
  int unsigned         gap_max;
  int unsigned         stall_pct;
  int unsigned         stall_left;
  logic                stall_on;

  brake_caliper_sequencer uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Sequence one caliper side for one tick
  function automatic void move_caliper(input bit side, input logic [HallW-1:0] hall,
                                       input logic req, input bit both_mode);
    logic [TicksW-1:0] goal;
    if (side_locked[side] != req && hall >= cfg_shadow.hall_threshold) begin
      pins.drive_forward = ~req;
      pins.drive_reverse = req;
      if (req)
        goal = both_mode ? cfg_shadow.apply_ticks_both : cfg_shadow.apply_ticks_single;
      else
        goal = both_mode ? cfg_shadow.release_ticks_both : cfg_shadow.release_ticks_single;
      side_ticks[side] = side_ticks[side] + TicksW'(1);
      if (side_ticks[side] == goal) begin
        pins.right_enable  = 1'b0;
        pins.left_enable   = 1'b0;
        pins.drive_forward = 1'b0;
        pins.drive_reverse = 1'b0;
        side_ticks[side]   = '0;
        side_locked[side]  = req;
        pins.brake_status  = req;
        pins.red_led       = both_mode ? 1'b1 : req;
        pins.green_led     = both_mode ? 1'b1 : ~req;
      end
    end
  endfunction

  // Advance the predictor by one tick and return the pins after it
  function automatic result_t predict_pins(input item_t t);
    if (cfg_shadow.control_mode) begin
      pins.right_enable = 1'b1;
      pins.left_enable  = 1'b1;
      move_caliper(SideRight, t.hall_right, t.lock_request, 1'b1);
    end else begin
      case (cfg_shadow.caliper_select)
        SEL_RIGHT: begin
          pins.right_enable = 1'b1;
          pins.left_enable  = 1'b0;
          move_caliper(SideRight, t.hall_right, t.lock_request, 1'b0);
        end
        SEL_LEFT: begin
          pins.right_enable = 1'b0;
          pins.left_enable  = 1'b1;
          move_caliper(SideLeft, t.hall_left, t.lock_request, 1'b0);
        end
        SEL_BOTH: begin
          pins.right_enable = 1'b1;
          pins.left_enable  = 1'b1;
          move_caliper(SideRight, t.hall_right, t.lock_request, 1'b0);
        end
        default: begin
          pins.right_enable = 1'b0;
          pins.left_enable  = 1'b0;
        end
      endcase
    end
    return pins;
  endfunction

  // Send one request, with a random gap at the start of each burst
  task automatic send_tick(input item_t t);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        @(negedge clk);
        item_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    item_valid = 1'b1;
    item       = t;
    do @(posedge clk); while (item_stall);
    pin_expect_q.push_back(predict_pins(t));
  endtask

  // Drop valid and wait until every result has drained
  task automatic wait_idle();
    @(negedge clk);
    item_valid = 1'b0;
    while (pin_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register while the block is idle
  task automatic write_reg(input cfg_index_e idx, input logic [HallW-1:0] val);
    wait_idle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CONTROL_MODE:   cfg_shadow.control_mode         = val[0];
      CFG_CALIPER_SELECT: cfg_shadow.caliper_select       = val[1:0];
      CFG_HALL_THRESHOLD: cfg_shadow.hall_threshold       = val;
      CFG_RELEASE_SINGLE: cfg_shadow.release_ticks_single = val[TicksW-1:0];
      CFG_APPLY_SINGLE:   cfg_shadow.apply_ticks_single   = val[TicksW-1:0];
      CFG_RELEASE_BOTH:   cfg_shadow.release_ticks_both   = val[TicksW-1:0];
      CFG_APPLY_BOTH:     cfg_shadow.apply_ticks_both     = val[TicksW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic item_t make_tick(input logic req, input logic [HallW-1:0] hr,
                                      input logic [HallW-1:0] hl);
    item_t t;
    t.lock_request = req;
    t.hall_right   = hr;
    t.hall_left    = hl;
    return t;
  endfunction

  // Hall sample: mostly at or above threshold, some below, some anywhere
  function automatic logic [HallW-1:0] pick_hall();
    int unsigned r;
    int unsigned thr;
    logic [HallW-1:0] v;
    thr = 32'(cfg_shadow.hall_threshold);
    r = $urandom_range(0, 99);
    if (r < 8)
      v = HallW'($urandom_range(0, 4095));
    else if (r < 20 && thr != 0)
      v = HallW'($urandom_range(0, thr - 1));
    else
      v = HallW'($urandom_range(thr, 4095));
    return v;
  endfunction

  // Tick count setting with the extremes weighted in
  function automatic logic [HallW-1:0] pick_count();
    int unsigned r;
    logic [HallW-1:0] v;
    r = $urandom_range(0, 9);
    case (r)
      0:       v = 12'd0;
      1:       v = 12'd31;
      2:       v = 12'd1;
      default: v = HallW'($urandom_range(1, 12));
    endcase
    return v;
  endfunction

  // Default registers: selection none keeps both enables low
  task automatic test_reset_defaults();
    gap_max   = 2;
    stall_pct = 25;
    send_tick(make_tick(1'b1, 12'd4095, 12'd4095));
    send_tick(make_tick(1'b0, 12'd0, 12'd0));
  endtask

  // Right side: idle below threshold, lock, hold, then release
  task automatic test_right_side();
    write_reg(CFG_CALIPER_SELECT, HallW'(SEL_RIGHT));
    write_reg(CFG_HALL_THRESHOLD, 12'd2048);
    write_reg(CFG_APPLY_SINGLE, 12'd2);
    write_reg(CFG_RELEASE_SINGLE, 12'd1);
    send_tick(make_tick(1'b1, 12'd2047, 12'd4095));
    send_tick(make_tick(1'b1, 12'd2048, 12'd0));
    send_tick(make_tick(1'b1, 12'd4095, 12'd0));
    send_tick(make_tick(1'b1, 12'd4095, 12'd0));
    send_tick(make_tick(1'b0, 12'd4095, 12'd0));
  endtask

  // Left side follows the left hall reading only
  task automatic test_left_side();
    write_reg(CFG_CALIPER_SELECT, HallW'(SEL_LEFT));
    send_tick(make_tick(1'b1, 12'd0, 12'd4095));
    send_tick(make_tick(1'b1, 12'd0, 12'd3000));
    send_tick(make_tick(1'b0, 12'd4095, 12'd2100));
  endtask

  // Selection both sequences the right side, then selection none
  task automatic test_both_select();
    write_reg(CFG_CALIPER_SELECT, HallW'(SEL_BOTH));
    send_tick(make_tick(1'b1, 12'd4095, 12'd0));
    send_tick(make_tick(1'b1, 12'd4095, 12'd0));
    write_reg(CFG_CALIPER_SELECT, HallW'(SEL_NONE));
    send_tick(make_tick(1'b0, 12'd4095, 12'd4095));
  endtask

  // Both-sides mode with threshold extremes and both-LED completion
  task automatic test_both_mode();
    write_reg(CFG_CONTROL_MODE, 12'd1);
    write_reg(CFG_HALL_THRESHOLD, 12'd0);
    write_reg(CFG_RELEASE_BOTH, 12'd1);
    write_reg(CFG_APPLY_BOTH, 12'd1);
    send_tick(make_tick(1'b0, 12'd0, 12'd0));
    send_tick(make_tick(1'b1, 12'd0, 12'd0));
    send_tick(make_tick(1'b0, 12'd0, 12'd4095));
    write_reg(CFG_HALL_THRESHOLD, 12'd4095);
    send_tick(make_tick(1'b1, 12'd4094, 12'd4095));
    send_tick(make_tick(1'b1, 12'd4095, 12'd0));
  endtask

  // Runs of one lock request over random settings and idle patterns
  task automatic test_random_runs();
    logic        req;
    int unsigned run_left;
    logic [HallW-1:0] thr;
    req = 1'b0;
    run_left = 0;
    for (int phase = 0; phase < 26; phase++) begin
      case ($urandom_range(0, 9))
        0:       thr = 12'd0;
        1:       thr = 12'd4095;
        default: thr = HallW'($urandom_range(0, 3000));
      endcase
      write_reg(CFG_CONTROL_MODE, ($urandom_range(0, 9) < 3) ? 12'd1 : 12'd0);
      write_reg(CFG_CALIPER_SELECT, HallW'($urandom_range(0, 3)));
      write_reg(CFG_HALL_THRESHOLD, thr);
      write_reg(CFG_RELEASE_SINGLE, pick_count());
      write_reg(CFG_APPLY_SINGLE, pick_count());
      write_reg(CFG_RELEASE_BOTH, pick_count());
      write_reg(CFG_APPLY_BOTH, pick_count());
      case (phase % 3)
        0:       gap_max = 0;
        1:       gap_max = 3;
        default: gap_max = 8;
      endcase
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 30;
        default: stall_pct = 70;
      endcase
      for (int n = 0; n < 75; n++) begin
        if (run_left == 0) begin
          if ($urandom_range(0, 4) != 0)
            req = ~req;
          run_left = $urandom_range(1, 45);
        end
        run_left--;
        send_tick(make_tick(req, pick_hall(), pick_hall()));
      end
    end
  endtask

  // Receiver stall pattern: random-length runs of stall or flow
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(1, 12);
      stall_on   = ($urandom_range(0, 99) < stall_pct);
    end
    stall_left--;
    result_stall = stall_on;
  end

  task automatic check_pin(input string name, input logic want, input logic got);
    if (got !== want) begin
      $error("%s mismatch: expected %b, got %b", name, want, got);
      error_count++;
    end
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pin_expect_q.size() == 0) begin
        $error("result with no pending request");
        error_count++;
      end else begin
        pin_want = pin_expect_q.pop_front();
        check_pin("right_enable",  pin_want.right_enable,  result.right_enable);
        check_pin("left_enable",   pin_want.left_enable,   result.left_enable);
        check_pin("drive_forward", pin_want.drive_forward, result.drive_forward);
        check_pin("drive_reverse", pin_want.drive_reverse, result.drive_reverse);
        check_pin("brake_status",  pin_want.brake_status,  result.brake_status);
        check_pin("red_led",       pin_want.red_led,       result.red_led);
        check_pin("green_led",     pin_want.green_led,     result.green_led);
      end
    end
  end

  // Hold reset, run each test in turn, then report
  initial begin
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    result_stall = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_CONTROL_MODE;
    cfg_data     = '0;
    error_count  = 0;
    burst_left   = 0;
    gap_max      = 0;
    stall_pct    = 0;
    stall_left   = 0;
    stall_on     = 1'b0;
    cfg_shadow.control_mode         = 1'b0;
    cfg_shadow.caliper_select       = SEL_NONE;
    cfg_shadow.hall_threshold       = HallThresholdReset;
    cfg_shadow.release_ticks_single = ReleaseSingleReset;
    cfg_shadow.apply_ticks_single   = ApplySingleReset;
    cfg_shadow.release_ticks_both   = ReleaseBothReset;
    cfg_shadow.apply_ticks_both     = ApplyBothReset;
    side_locked[SideRight] = 1'b0;
    side_locked[SideLeft]  = 1'b0;
    side_ticks[SideRight]  = '0;
    side_ticks[SideLeft]   = '0;
    pins = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_right_side();
    test_left_side();
    test_both_select();
    test_both_mode();
    test_random_runs();

    wait_idle();
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("brake_caliper_sequencer regression: pass");
    else
      $display("brake_caliper_sequencer regression: fail");
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("brake_caliper_sequencer regression: fail");
    $finish;
  end

endmodule

>>> sim.f
design/bcs_pkg.sv
design/bcs_cfg.sv
design/bcs_core.sv
design/brake_caliper_sequencer.sv
tb/brake_caliper_sequencer_tb.sv
